@@ design/pftr_pkg.sv @@
package pftr_pkg;
  localparam int SCREEN_WIDTH   = 128;
  localparam int SCREEN_HEIGHT  = 64;
  localparam int MAX_GLYPH_ROWS = 16;

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int FB_AW      = $clog2(FB_DEPTH);
  localparam int FONT_WORDS = 1536;
  localparam int FONT_AW    = 11;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;

  localparam logic [2:0] OP_FILL   = 3'd0;
  localparam logic [2:0] OP_PIXEL  = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_CHAR   = 3'd3;
  localparam logic [2:0] OP_NLINE  = 3'd4;
  localparam logic [2:0] OP_FONT   = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;
  localparam logic [2:0] OP_CLEAR  = 3'd7;

  localparam logic [1:0] REG_GLYPH_W = 2'd0;
  localparam logic [1:0] REG_GLYPH_H = 2'd1;
  localparam logic [1:0] REG_LINE_GAP = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
endpackage

@@ design/page_framebuffer_text_renderer_core.sv @@
// channel | ports                    | tdata / tuser
// in      | in_tvalid/in_tready      | tdata: pos_x, pos_y, ink, char_code, font_addr,
//         |                          |        font_word; tuser: operation
// out     | out_tvalid/out_tready    | tdata: read_byte, char_echo; tuser: char_refused
// cfg     | cfg_valid/cfg_ready      | cfg_index, cfg_data
// One item at a time. Cursor, next line, font load: straight to the result; pixel: read, write;
// read: read, wait; fill and clear: one frame byte a cycle through the single write port;
// char: per row a font read, then one read-modify-write of a frame byte per pixel.
// After reset a clearing pass over all FB_DEPTH frame bytes runs before the first word is taken.
// A result waiting on out_tready holds the next item at its end, not its acceptance.
module page_framebuffer_text_renderer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x[7:0] pos_y[15:8] ink[16] char_code[24:17] font_addr[35:25] font_word[51:36]
  input  logic [pftr_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[2:0]
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_byte[7:0] char_echo[15:8]
  output logic [pftr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // char_refused[0]
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);
  import pftr_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FROW  = 4'd2;
  localparam logic [3:0] S_FWAIT = 4'd3;
  localparam logic [3:0] S_PRD   = 4'd4;
  localparam logic [3:0] S_PWR   = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [7:0]  fb_mem [FB_DEPTH];
  logic [15:0] font_mem [FONT_WORDS];

  logic [3:0]  state_r;
  logic [4:0]  gw_r, gh_r;
  logic [5:0]  gap_r;
  logic [7:0]  cur_col_r, cur_row_r;
  logic [7:0]  org_col_r, org_row_r;
  logic [4:0]  i_r, j_r;
  logic        char_r, ink_r, emit_r;
  logic [7:0]  fill_val_r;
  logic [FB_AW:0] sweep_r;
  logic [11:0] gbase_r;
  logic [15:0] word_r;
  logic [7:0]  fb_rdata_r;
  logic [15:0] font_rdata_r;
  logic        font_ok_r;
  logic [7:0]  rd_x_r, rd_y_r;
  logic [7:0]  res_byte_r, res_echo_r;
  logic        res_ref_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_echo_r;
  logic        out_ref_r;

  logic [7:0]  px, py, code;
  logic        ink;
  logic [10:0] faddr;
  logic [15:0] fword;
  assign px    = in_tdata[7:0];
  assign py    = in_tdata[15:8];
  assign ink   = in_tdata[16];
  assign code  = in_tdata[24:17];
  assign faddr = in_tdata[35:25];
  assign fword = in_tdata[51:36];

  logic [4:0] gh_used;
  assign gh_used = (6'(gh_r) > 6'(MAX_GLYPH_ROWS)) ? 5'(MAX_GLYPH_ROWS) : gh_r;

  logic nl_ok;
  logic [7:0] nl_row;
  assign nl_ok  = (10'(cur_row_r) + 10'(gh_used) * 10'd2 + 10'(gap_r))
                  < 10'(SCREEN_HEIGHT);
  assign nl_row = 8'(cur_row_r + 8'(gh_used) + 8'(gap_r));

  logic wrap, code_ok, char_refuse;
  assign wrap        = (9'(cur_col_r) + 9'(gw_r)) >= 9'(SCREEN_WIDTH);
  assign code_ok     = (code >= FIRST_CODE) && (code <= LAST_CODE);
  assign char_refuse = !code_ok || (wrap && !nl_ok);

  // Pixel being painted
  logic [7:0] pix_x, pix_y;
  logic       pix_in, pix_on, pix_white;
  logic [4:0] pix_page;
  logic [FB_AW-1:0] pix_addr;
  assign pix_x    = 8'(org_col_r + 8'(j_r));
  assign pix_y    = 8'(org_row_r + 8'(i_r));
  assign pix_in   = (9'(pix_x) < 9'(SCREEN_WIDTH)) && (9'(pix_y) < 9'(SCREEN_HEIGHT));
  assign pix_page = pix_y[7:3];
  assign pix_addr = FB_AW'(pix_x) + FB_AW'(pix_page) * FB_AW'(SCREEN_WIDTH);
  assign pix_on   = (j_r < 5'd16) ? word_r[4'(5'd15 - j_r)] : 1'b0;
  assign pix_white = char_r ? (pix_on ? ink_r : ~ink_r) : ink_r;

  logic [FB_AW-1:0] rd_addr;
  assign rd_addr = FB_AW'(rd_x_r) + FB_AW'(rd_y_r) * FB_AW'(SCREEN_WIDTH);

  logic [11:0] font_raddr;
  assign font_raddr = 12'(gbase_r + 12'(i_r));

  logic [FB_AW-1:0] fb_raddr;
  assign fb_raddr = (state_r == S_RRD) ? rd_addr : pix_addr;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  logic [7:0] pix_mod;
  assign pix_mod = pix_white ? (fb_rdata_r | (8'd1 << pix_y[2:0]))
                             : (fb_rdata_r & ~(8'd1 << pix_y[2:0]));

  // Memories
  always_ff @(posedge clk) begin
    fb_rdata_r <= fb_mem[fb_raddr];
    if (state_r == S_CLR) begin
      fb_mem[sweep_r[FB_AW-1:0]] <= fill_val_r;
    end else if (state_r == S_PWR && pix_in) begin
      fb_mem[pix_addr] <= pix_mod;
    end
  end

  always_ff @(posedge clk) begin
    font_rdata_r <= font_mem[font_raddr[FONT_AW-1:0]];
    font_ok_r    <= font_raddr < 12'(FONT_WORDS);
    if (in_acc && in_tuser == OP_FONT && faddr < 11'(FONT_WORDS)) begin
      font_mem[faddr] <= fword;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      fill_val_r  <= 8'h00;
      emit_r      <= 1'b0;
      gw_r        <= 5'd8;
      gh_r        <= 5'd8;
      gap_r       <= 6'd0;
      cur_col_r   <= 8'd0;
      cur_row_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GLYPH_W:  gw_r  <= cfg_data[4:0];
          REG_GLYPH_H:  gh_r  <= cfg_data[4:0];
          REG_LINE_GAP: gap_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      // drop a taken word unless a new one replaces it this cycle
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_CLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (FB_AW+1)'(FB_DEPTH - 1)) begin
            state_r <= emit_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_byte_r <= 8'd0;
            res_echo_r <= (in_tuser == OP_CHAR && !char_refuse) ? code : 8'd0;
            res_ref_r  <= (in_tuser == OP_CHAR) && char_refuse;
            ink_r      <= ink;
            i_r        <= '0;
            j_r        <= '0;
            case (in_tuser)
              OP_FILL: begin
                fill_val_r <= ink ? 8'hFF : 8'h00;
                sweep_r    <= '0;
                emit_r     <= 1'b1;
                state_r    <= S_CLR;
              end
              OP_CLEAR: begin
                fill_val_r <= 8'h00;
                sweep_r    <= '0;
                emit_r     <= 1'b1;
                cur_col_r  <= 8'd0;
                cur_row_r  <= 8'd0;
                state_r    <= S_CLR;
              end
              OP_PIXEL: begin
                org_col_r <= px;
                org_row_r <= py;
                char_r    <= 1'b0;
                state_r   <= S_PRD;
              end
              OP_CURSOR: begin
                cur_col_r <= px;
                cur_row_r <= py;
                state_r   <= S_DONE;
              end
              OP_NLINE: begin
                if (nl_ok) begin
                  cur_col_r <= 8'd0;
                  cur_row_r <= nl_row;
                end
                state_r <= S_DONE;
              end
              OP_READ: begin
                rd_x_r  <= px;
                rd_y_r  <= py;
                state_r <= (9'(px) < 9'(SCREEN_WIDTH) && 9'(py) < 9'(PAGE_COUNT)) ?
                           S_RRD : S_DONE;
              end
              OP_CHAR: begin
                char_r  <= 1'b1;
                gbase_r <= 12'(7'(code - FIRST_CODE)) * 12'(gh_used);
                if (!char_refuse) begin
                  if (wrap) begin
                    org_col_r <= 8'd0;
                    org_row_r <= nl_row;
                    cur_row_r <= nl_row;
                    cur_col_r <= 8'(gw_r);
                  end else begin
                    org_col_r <= cur_col_r;
                    org_row_r <= cur_row_r;
                    cur_col_r <= 8'(cur_col_r + 8'(gw_r));
                  end
                end
                state_r <= (!char_refuse && gw_r != 5'd0 && gh_used != 5'd0) ?
                           S_FROW : S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_FROW:  state_r <= S_FWAIT;
        S_FWAIT: begin
          word_r  <= font_ok_r ? font_rdata_r : 16'h0000;
          state_r <= S_PRD;
        end
        S_PRD:   state_r <= S_PWR;
        S_PWR: begin
          // advance column, then row
          if (!char_r) begin
            state_r <= S_DONE;
          end else if (j_r + 5'd1 == gw_r) begin
            j_r <= '0;
            i_r <= i_r + 5'd1;
            state_r <= (i_r + 5'd1 == gh_used) ? S_DONE : S_FROW;
          end else begin
            j_r     <= j_r + 5'd1;
            state_r <= S_PRD;
          end
        end
        S_RRD:   state_r <= S_RWAIT;
        S_RWAIT: begin
          res_byte_r <= fb_rdata_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          emit_r <= 1'b0;
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= res_byte_r;
            out_echo_r  <= res_echo_r;
            out_ref_r   <= res_ref_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_echo_r, out_byte_r};
  assign out_tuser  = out_ref_r;
endmodule
